[rtl/core/swgd_pkg.sv]
// Shared types and constants for the sequence window gap detector.
// No dependencies; every other file in rtl/core imports this package.
package swgd_pkg;

  // Ring depth and derived widths
  localparam int WINDOW   = 32;
  localparam int STEP_W   = $clog2(WINDOW);
  localparam int SEQ_W    = 32;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = STATUS_W + 3 * SEQ_W;
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WINDOW - 1);

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_IN_ORDER  = 2'd0,
    ST_REORDERED = 2'd1,
    ST_MISSED    = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_INSERT
  } state_t;

  // Commands from the controller to the cell row
  typedef struct packed {
    logic shift;   // rotate the row one place towards the head
    logic insert;  // head cell takes the new number instead of its neighbour
  } chain_ctrl_t;

endpackage

[rtl/core/swgd_cell.sv]
// One storage cell of the window row: a 32-bit entry that takes its
// neighbour's value, or the loaded value, on a shift. Depends on swgd_pkg.
module swgd_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic                      load,
  input  logic [swgd_pkg::SEQ_W-1:0] load_val,
  input  logic [swgd_pkg::SEQ_W-1:0] nbr_in,
  output logic [swgd_pkg::SEQ_W-1:0] q
);
  import swgd_pkg::*;

  logic [SEQ_W-1:0] val_r;
  logic [SEQ_W-1:0] val_nxt;

  // Pick neighbour or loaded value on a shift, else hold
  always_comb begin
    val_nxt = val_r;
    if (shift) begin
      val_nxt = load ? load_val : nbr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign q = val_r;

endmodule

[rtl/core/swgd_chain.sv]
// Circular row of WINDOW cells. Cell 0 is the head: at rest it holds the
// newest number, cell 1 the oldest, and so on forward round the ring.
// Depends on swgd_pkg and swgd_cell.
module swgd_chain (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swgd_pkg::chain_ctrl_t       ctrl,
  input  logic [swgd_pkg::SEQ_W-1:0]  new_val,
  output logic [swgd_pkg::SEQ_W-1:0]  head
);
  import swgd_pkg::*;

  logic [SEQ_W-1:0] q [WINDOW];

  // Each cell takes from the next one up; the last wraps to the head
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int NXT = (i + 1) % WINDOW;
    swgd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (ctrl.shift),
      .load     ((i == 0) ? ctrl.insert : 1'b0),
      .load_val (new_val),
      .nbr_in   (q[NXT]),
      .q        (q[i])
    );
  end

  assign head = q[0];

endmodule

[rtl/core/seq_window_gap_detector.sv]
// Top level of the sequence window gap detector: controller, head compare
// and output register around the cell row. Depends on swgd_pkg, swgd_chain.
//
//  channel | direction | tdata fields (lsb first)
//  in_     | slave     | seq_number[31:0]
//  out_    | master    | status[1:0], missed_count[33:2], window_low[65:34],
//          |           | window_high[97:66], zero pad [103:98]
//
// An item is taken, then the row rotates once in full past the single head
// comparator, and then the new number is written into the head cell.
// Reset (rst_n low, synchronous) clears the ring to zero, the controller
// state, the step count, the hit flag and the output valid flag.
// A result waits in the output register; the next item is taken meanwhile,
// and only the write step stalls until that register is free.
module seq_window_gap_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // seq_number[31:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [swgd_pkg::OUT_TD_W-1:0] out_tdata   // status, missed_count,
                                                    // window_low, window_high
);
  import swgd_pkg::*;

  state_t           state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SEQ_W-1:0] n_r, n_nxt;
  logic [SEQ_W-1:0] newest_r, newest_nxt;
  logic [SEQ_W-1:0] hit_r, hit_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  chain_ctrl_t      ctrl;
  logic [SEQ_W-1:0] head;
  logic             in_xfer;
  logic             out_free;
  logic             hit;
  logic             commit;

  status_t          res_status;
  logic [SEQ_W-1:0] res_gap;
  logic [SEQ_W-1:0] res_low;

  swgd_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .new_val (n_r),
    .head    (head)
  );

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign commit   = (state_r == S_INSERT) && out_free;

  // Stop condition at the head: value plus one matches, or value is above
  assign hit = ((head + SEQ_W'(1)) == n_r) || (head > n_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_SEARCH;
      S_SEARCH: if (step_r == LAST_STEP) state_nxt = S_INSERT;
      S_INSERT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_tready   = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.insert = 1'b0;
    case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_SEARCH: ctrl.shift = 1'b1;
      S_INSERT: begin
        ctrl.shift  = out_free;
        ctrl.insert = out_free;
      end
      default: ;
    endcase
  end

  // Capture the item and newest value, count steps, latch the first hit
  always_comb begin
    n_nxt      = n_r;
    newest_nxt = newest_r;
    step_nxt   = step_r;
    found_nxt  = found_r;
    hit_nxt    = hit_r;
    if (in_xfer) begin
      n_nxt      = in_tdata;
      newest_nxt = head;
      step_nxt   = '0;
      found_nxt  = 1'b0;
    end else if (state_r == S_SEARCH) begin
      step_nxt = step_r + STEP_W'(1);
      if (!found_r && (step_r != LAST_STEP) && hit) begin
        found_nxt = 1'b1;
        hit_nxt   = head;
      end
    end
  end

  // Classify the item
  always_comb begin
    res_gap = '0;
    res_low = '0;
    if (!found_r) begin
      res_status = ST_MISSED;
      res_gap    = n_r - newest_r;
    end else if ((newest_r + SEQ_W'(1)) != n_r) begin
      res_status = ST_REORDERED;
      res_low    = hit_r;
    end else begin
      res_status = ST_IN_ORDER;
    end
  end

  // Load the output register on the write step, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {newest_r, res_low, res_gap, res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    newest_r   <= newest_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TD_W - OUT_W){1'b0}}, out_data_r};

  // The last rotation step always hands over to the write step
  a_search_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && step_r == LAST_STEP) |=> (state_r == S_INSERT))
    else $error("search did not end in the write step");

  // After the write step the head holds the number just taken
  a_head_written: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (head == $past(n_r)))
    else $error("head cell does not hold the new number");

  // No result carries the unused status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[STATUS_W-1:0] != 2'd3))
    else $error("invalid status code on output");

  // A missed result reports no matched entry
  a_missed_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[STATUS_W-1:0] == ST_MISSED)
      |-> (out_tdata[STATUS_W+2*SEQ_W-1:STATUS_W+SEQ_W] == '0))
    else $error("missed result carries a matched value");

endmodule
